>>> hw/rtl/lrcd_pkg.sv
// Shared types, codes and the CRC-32C byte update for the log record deframer.
package lrcd_pkg;

  localparam int unsigned OFFSET_BITS_DEFAULT = 48;
  localparam int unsigned HEADER_SIZE         = 8;
  localparam int unsigned GOOD_OFFSET_W       = 48;

  localparam logic [31:0] CRC_POLY   = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_XOROUT = 32'hFFFF_FFFF;

  // input command codes
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // register index (byte address bit 2)
  localparam logic REG_TRUNCATE = 1'b0;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CLEAN_END = 3'd1,
    ST_TRUNC_HDR = 3'd2,
    ST_TRUNC_PAY = 3'd3,
    ST_CRC_BAD   = 3'd4
  } status_e;

  typedef struct packed {
    logic                     valid;
    logic [7:0]               out_byte;
    logic                     byte_valid;
    logic                     record_end;
    status_e                  status;
    logic                     truncate_request;
    logic [GOOD_OFFSET_W-1:0] good_offset;
  } lrcd_result_t;

  // reflected CRC-32C, one byte
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/lrcd_parser.sv
// Record parser: header capture, CRC-32C check, length and offset tracking.
module lrcd_parser
  import lrcd_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         fire_i,
  input  logic         command_i,
  input  logic [7:0]   data_byte_i,
  input  logic         truncate_en_i,
  output lrcd_result_t result_o
);

  localparam logic PHASE_HEADER  = 1'b0;
  localparam logic PHASE_PAYLOAD = 1'b1;
  localparam logic [2:0] LAST_HDR_BYTE = 3'(HEADER_SIZE - 1);

  logic                   phase_q, phase_d;
  logic [2:0]             hdr_cnt_q, hdr_cnt_d;
  logic [31:0]            stored_crc_q, stored_crc_d;
  logic [31:0]            bytes_left_q, bytes_left_d;
  logic [31:0]            crc_q, crc_d;
  logic [OFFSET_BITS-1:0] log_offset_q, log_offset_d;
  logic [OFFSET_BITS-1:0] good_offset_q, good_offset_d;
  logic                   halted_q, halted_d;
  logic                   close_rec;
  lrcd_result_t           res;

  always_comb begin
    phase_d       = phase_q;
    hdr_cnt_d     = hdr_cnt_q;
    stored_crc_d  = stored_crc_q;
    bytes_left_d  = bytes_left_q;
    crc_d         = crc_q;
    log_offset_d  = log_offset_q;
    good_offset_d = good_offset_q;
    halted_d      = halted_q;
    close_rec     = 1'b0;
    res           = '0;
    res.status    = ST_OK;

    if (fire_i && !halted_q) begin
      if (command_i == CMD_END) begin
        res.valid      = 1'b1;
        res.record_end = 1'b1;
        if (phase_q == PHASE_PAYLOAD) begin
          res.status = ST_TRUNC_PAY;
        end else if (hdr_cnt_q != '0) begin
          res.status = ST_TRUNC_HDR;
        end else begin
          res.status = ST_CLEAN_END;
        end
        res.truncate_request = (res.status != ST_CLEAN_END) && truncate_en_i;
        halted_d = 1'b1;
      end else begin
        log_offset_d = log_offset_q + OFFSET_BITS'(1);
        if (phase_q == PHASE_HEADER) begin
          if (hdr_cnt_q == '0) begin
            crc_d = CRC_INIT;
          end
          // little-endian fields shift in from the top
          if (!hdr_cnt_q[2]) begin
            stored_crc_d = {data_byte_i, stored_crc_q[31:8]};
          end else begin
            bytes_left_d = {data_byte_i, bytes_left_q[31:8]};
            crc_d        = crc32c_byte(crc_q, data_byte_i);
          end
          hdr_cnt_d = hdr_cnt_q + 3'd1;
          if (hdr_cnt_q == LAST_HDR_BYTE) begin
            if (bytes_left_d != '0) begin
              phase_d = PHASE_PAYLOAD;
            end else begin
              close_rec = 1'b1;
            end
          end
        end else begin
          crc_d          = crc32c_byte(crc_q, data_byte_i);
          res.valid      = 1'b1;
          res.out_byte   = data_byte_i;
          res.byte_valid = 1'b1;
          bytes_left_d   = bytes_left_q - 32'd1;
          close_rec      = (bytes_left_q == 32'd1);
        end

        if (close_rec) begin
          res.valid      = 1'b1;
          res.record_end = 1'b1;
          if ((crc_d ^ CRC_XOROUT) == stored_crc_q) begin
            good_offset_d = log_offset_d;
            phase_d       = PHASE_HEADER;
          end else begin
            res.status           = ST_CRC_BAD;
            res.truncate_request = truncate_en_i;
            halted_d             = 1'b1;
          end
        end
      end
    end
    res.good_offset = GOOD_OFFSET_W'(good_offset_d);
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PHASE_HEADER;
      hdr_cnt_q     <= '0;
      stored_crc_q  <= '0;
      bytes_left_q  <= '0;
      crc_q         <= CRC_INIT;
      log_offset_q  <= '0;
      good_offset_q <= '0;
      halted_q      <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      hdr_cnt_q     <= hdr_cnt_d;
      stored_crc_q  <= stored_crc_d;
      bytes_left_q  <= bytes_left_d;
      crc_q         <= crc_d;
      log_offset_q  <= log_offset_d;
      good_offset_q <= good_offset_d;
      halted_q      <= halted_d;
    end
  end

endmodule

>>> hw/rtl/lrcd_out_reg.sv
// Result register between the parser and the output channel.
module lrcd_out_reg
  import lrcd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  lrcd_result_t result_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output lrcd_result_t result_o
);

  logic         valid_q, valid_d;
  lrcd_result_t data_q;
  logic         load;

  // slot is free when empty or being drained this cycle
  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (valid_q && out_ready_i) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d = result_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && result_i.valid) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule

>>> hw/rtl/log_record_crc_deframer_unit.sv
// Log record deframer with CRC-32C check: top level, APB register and channel wiring.
//
// Input channel: one word per log byte (command_i = data) or an end-of-log
// word (command_i = end), valid/ready. Output channel: valid/ready, one word
// per payload byte; the last payload byte of a record (or a bare word for a
// zero-length record) carries record_end_o and status ok or CRC mismatch.
// End of log yields one word: clean end, truncated header or truncated
// payload, with good_offset_o and truncate_request_o when enabled.
// Output valid rises in the cycle after input accept. Throughput is one
// input word per cycle while output is taken; the CRC byte update and counters are
// combinational, ahead of the result register. Header bytes give no output word.
// After an error or an end-of-log report the block halts: it keeps taking
// words but gives no output until reset. Reset clears all parsing state and
// the truncate_damaged_tail register (APB offset 0x0, bit 0).
// A stalled receiver holds the result register; input ready drops only
// while that register is full and not being taken.
module log_record_crc_deframer_unit
  import lrcd_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        record_end_o,
  output logic [2:0]  status_o,
  output logic        truncate_request_o,
  output logic [47:0] good_offset_o
);

  logic         trunc_en_q;
  logic         in_ready;
  logic         in_fire;
  lrcd_result_t parse_res;
  lrcd_result_t out_res;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trunc_en_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TRUNCATE) begin
      trunc_en_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_TRUNCATE) ? {31'h0, trunc_en_q} : 32'h0;

  assign in_fire    = in_valid_i && in_ready;
  assign in_ready_o = in_ready;

  lrcd_parser #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (in_fire),
    .command_i    (command_i),
    .data_byte_i  (data_byte_i),
    .truncate_en_i(trunc_en_q),
    .result_o     (parse_res)
  );

  lrcd_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready),
    .result_i   (parse_res),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .result_o   (out_res)
  );

  assign out_byte_o         = out_res.out_byte;
  assign byte_valid_o       = out_res.byte_valid;
  assign record_end_o       = out_res.record_end;
  assign status_o           = out_res.status;
  assign truncate_request_o = out_res.truncate_request;
  assign good_offset_o      = out_res.good_offset;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the CRC-32C log record deframer: records, end of log, register.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lrcd_pkg::*;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  typedef enum logic {IN_HEADER, IN_PAYLOAD} parse_phase_e;

  typedef struct {
    logic [7:0]               out_byte;
    logic                     byte_valid;
    logic                     record_end;
    status_e                  status;
    logic                     trunc_req;
    logic [GOOD_OFFSET_W-1:0] good_offset;
  } deframed_word_t;

  typedef struct {
    logic [31:0]              len;
    logic [7:0]               fill;
    logic [7:0]               stride;
    bit                       typed;
    status_e                  want_status;
    logic [GOOD_OFFSET_W-1:0] want_offset;
  } record_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid_i, in_ready_o, command_i;
  logic [7:0]  data_byte_i;
  logic        out_valid_o, out_ready_i;
  logic [7:0]  out_byte_o;
  logic        byte_valid_o, record_end_o, truncate_request_o;
  logic [2:0]  status_o;
  logic [47:0] good_offset_o;

  log_record_crc_deframer_unit u_top (.*);

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // parser state mirrored by the predictor
  parse_phase_e                   ph        = IN_HEADER;
  logic [2:0]                     hdr_idx   = '0;
  logic [31:0]                    want_crc  = '0;
  logic [31:0]                    len_acc   = '0;
  logic [31:0]                    left_cnt  = '0;
  logic [31:0]                    crc_acc   = CRC_INIT;
  logic [OFFSET_BITS_DEFAULT-1:0] pos       = '0;
  logic [OFFSET_BITS_DEFAULT-1:0] good_pos  = '0;
  bit                             stopped   = 1'b0;
  logic                           trunc_en  = 1'b0;

  deframed_word_t pending_words[$];
  int unsigned    mismatches   = 0;
  int unsigned    words_sent   = 0;
  int unsigned    bytes_seen   = 0;
  int unsigned    records_ok   = 0;
  int unsigned    cfg_writes   = 0;
  status_e        final_status = ST_OK;
  logic           final_trunc  = 1'b0;
  bit             gaps_on      = 1'b1;
  bit             hold_req     = 1'b0;

  record_row_t directed_rows[3] = '{
    '{32'd0, 8'h00, 8'h00, 1'b1, ST_OK, 48'd8},   // empty record: bare record end
    '{32'd2, 8'h00, 8'hFF, 1'b1, ST_OK, 48'd18},  // payload 0x00 then 0xFF
    '{32'd1, 8'h5A, 8'h00, 1'b0, ST_OK, 48'd0}
  };

  task automatic log_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic logic [31:0] crc32c_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ b[k]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  // one log word in, at most one output word predicted
  task automatic deframe_item(input logic cmd, input logic [7:0] b, output bit emit,
                              output deframed_word_t w);
    w.out_byte = '0; w.byte_valid = 1'b0; w.record_end = 1'b0;
    w.status = ST_OK; w.trunc_req = 1'b0; w.good_offset = '0;
    emit = 1'b0;
    if (stopped) return;
    if (cmd == CMD_END) begin
      emit = 1'b1;
      w.record_end = 1'b1;
      if (ph == IN_PAYLOAD) w.status = ST_TRUNC_PAY;
      else if (hdr_idx != 0) w.status = ST_TRUNC_HDR;
      else w.status = ST_CLEAN_END;
      w.trunc_req = (w.status != ST_CLEAN_END) && trunc_en;
      w.good_offset = good_pos[GOOD_OFFSET_W-1:0];
      stopped = 1'b1;
      return;
    end
    pos = pos + 1'b1;
    if (ph == IN_HEADER) begin
      if (hdr_idx == 0) begin
        want_crc = '0;
        crc_acc = CRC_INIT;
      end
      if (hdr_idx < 4) begin
        want_crc[8*hdr_idx +: 8] = b;
      end else begin
        if (hdr_idx == 4) len_acc = '0;
        len_acc[8*(hdr_idx-4) +: 8] = b;
        crc_acc = crc32c_step(crc_acc, b);
      end
      hdr_idx = hdr_idx + 1'b1;
      if (hdr_idx != 0) return;
      left_cnt = len_acc;
      if (left_cnt != 0) begin
        ph = IN_PAYLOAD;
        return;
      end
    end else begin
      crc_acc = crc32c_step(crc_acc, b);
      w.out_byte = b;
      w.byte_valid = 1'b1;
      left_cnt = left_cnt - 1'b1;
    end
    emit = 1'b1;
    if (left_cnt == 0) begin
      w.record_end = 1'b1;
      if ((crc_acc ^ CRC_XOROUT) == want_crc) begin
        good_pos = pos;
        ph = IN_HEADER;
      end else begin
        w.status = ST_CRC_BAD;
        w.trunc_req = trunc_en;
        stopped = 1'b1;
      end
    end
    w.good_offset = good_pos[GOOD_OFFSET_W-1:0];
  endtask

  // called at a rising edge; returns at the edge that takes the word
  task automatic send_word(input logic cmd, input logic [7:0] b);
    bit took;
    bit emit;
    deframed_word_t w;
    while (gaps_on && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    data_byte_i <= b;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    words_sent++;
    deframe_item(cmd, b, emit, w);
    if (emit) pending_words = {pending_words, w};
  endtask

  task automatic send_u32(input logic [31:0] v);
    for (int k = 0; k < 4; k++) send_word(CMD_DATA, v[8*k +: 8]);
  endtask

  task automatic send_record(input logic [31:0] len, input logic [7:0] fill,
                             input logic [7:0] stride, input bit rnd, input bit bad_crc);
    logic [7:0]  body[$];
    logic [31:0] c;
    c = CRC_INIT;
    for (int k = 0; k < 4; k++) c = crc32c_step(c, len[8*k +: 8]);
    for (int unsigned k = 0; k < len; k++) begin
      body = {body, (rnd ? 8'($urandom) : 8'(fill + k * stride))};
      c = crc32c_step(c, body[k]);
    end
    c = c ^ CRC_XOROUT;
    if (bad_crc) c = c ^ (32'h1 << $urandom_range(31));
    send_u32(c);
    send_u32(len);
    foreach (body[k]) send_word(CMD_DATA, body[k]);
  endtask

  task automatic random_records(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    logic [31:0] len;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 10) len = 0;
      else if (pick < 85) len = $urandom_range(12, 1);
      else len = $urandom_range(80, 13);
      send_record(len, 8'h00, 8'h00, 1'b1, 1'b0);
    end
  endtask

  // stop offering words and let the block empty out
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // write, then read back over a back-to-back transfer
  task automatic write_truncate(input logic v);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TRUNCATE, 2'b00};
    pwdata  <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    trunc_en = v;
    cfg_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    rd = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== 32'(v)) log_mismatch("truncate_damaged_tail readback", 64'(rd), 64'(v));
  endtask

  initial begin : receiver
    deframed_word_t got, want;
    bit fire;
    int unsigned hold_left;
    hold_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      fire = out_valid_o && out_ready_i;
      got.out_byte    = out_byte_o;
      got.byte_valid  = byte_valid_o;
      got.record_end  = record_end_o;
      got.status      = status_e'(status_o);
      got.trunc_req   = truncate_request_o;
      got.good_offset = good_offset_o;
      @(posedge clk_i);
      if (fire) begin
        if (pending_words.size() == 0) begin
          log_mismatch("output word with nothing expected", 64'(got.out_byte), 64'h0);
        end else begin
          want = pending_words.pop_front();
          if (got.out_byte !== want.out_byte)
            log_mismatch("out_byte", 64'(got.out_byte), 64'(want.out_byte));
          if (got.byte_valid !== want.byte_valid)
            log_mismatch("byte_valid", 64'(got.byte_valid), 64'(want.byte_valid));
          if (got.record_end !== want.record_end)
            log_mismatch("record_end", 64'(got.record_end), 64'(want.record_end));
          if (got.status !== want.status)
            log_mismatch("status", 64'(got.status), 64'(want.status));
          if (got.trunc_req !== want.trunc_req)
            log_mismatch("truncate_request", 64'(got.trunc_req), 64'(want.trunc_req));
          if (got.good_offset !== want.good_offset)
            log_mismatch("good_offset", 64'(got.good_offset), 64'(want.good_offset));
          if (got.byte_valid === 1'b1) bytes_seen++;
          if (got.record_end === 1'b1 && got.status == ST_OK) records_ok++;
          if (got.record_end === 1'b1) begin
            final_status = got.status;
            final_trunc  = got.trunc_req;
          end
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(gaps_on && $urandom_range(99) < 9);
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] len;
    int unsigned n;
    int unsigned last;
    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid_i  <= 1'b0;
    command_i   <= CMD_DATA;
    data_byte_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_truncate(1'b1);
    foreach (directed_rows[r]) begin
      send_record(directed_rows[r].len, directed_rows[r].fill, directed_rows[r].stride,
                  1'b0, 1'b0);
      if (directed_rows[r].typed) begin
        last = pending_words.size() - 1;
        pending_words[last].record_end  = 1'b1;
        pending_words[last].status      = directed_rows[r].want_status;
        pending_words[last].good_offset = directed_rows[r].want_offset;
      end
    end

    settle();
    write_truncate(1'b0);
    random_records(225);

    // no idling on either side for this stretch
    settle();
    write_truncate(1'b1);
    gaps_on = 1'b0;
    random_records(225);
    gaps_on = 1'b1;

    // receiver holds off for a while so the input side backs up
    settle();
    write_truncate(1'b0);
    hold_req = 1'b1;
    random_records(225);

    settle();
    write_truncate(1'($urandom_range(1)));
    random_records(200);

    // the log closes one way per run; the block halts after it
    case ($urandom_range(3))
      0: send_word(CMD_END, 8'($urandom));
      1: begin
        n = $urandom_range(7, 1);
        repeat (n) send_word(CMD_DATA, 8'($urandom));
        send_word(CMD_END, 8'($urandom));
      end
      2: begin
        send_u32($urandom);
        len = $urandom;
        if (len < 16) len = len + 16;
        send_u32(len);
        n = $urandom_range(6);
        repeat (n) send_word(CMD_DATA, 8'($urandom));
        send_word(CMD_END, 8'($urandom));
      end
      default: begin
        send_record($urandom_range(12), 8'h00, 8'h00, 1'b1, 1'b1);
        send_word(CMD_END, 8'($urandom));
      end
    endcase
    // halted: these words are taken and give nothing
    repeat (3) send_word(CMD_DATA, 8'($urandom));
    send_word(CMD_END, 8'($urandom));
    settle();

    $display("Covered: %0d log words, %0d records passed CRC, %0d payload bytes, %0d reg writes",
             words_sent, records_ok, bytes_seen, cfg_writes);
    $display("Covered: log closed with %s, truncate request %0b", final_status.name(),
             final_trunc);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/lrcd_pkg.sv
hw/rtl/lrcd_parser.sv
hw/rtl/lrcd_out_reg.sv
hw/rtl/log_record_crc_deframer_unit.sv
tb/testbench.sv
